[src/lpi_pkg.sv]
`default_nettype none
package lpi_pkg;

  localparam int COORD_BITS      = 12;
  localparam int COLOR_BITS      = 32;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int PROD_BITS       = 2 * COORD_BITS;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [COLOR_BITS-1:0] color_t;
  typedef logic [PROD_BITS-1:0]  prod_t;

  typedef struct packed {
    coord_t x_start;
    coord_t y_start;
    coord_t x_end;
    coord_t y_end;
    coord_t step_index;
    color_t pixel_color;
  } in_req_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    color_t out_color;
    logic   in_range;
    logic   final_pixel;
  } out_res_t;

  // classified line, one queue entry
  typedef struct packed {
    coord_t major_start;
    coord_t minor_start;
    coord_t step;
    coord_t len;
    coord_t minor_mag;
    logic   major_neg;
    logic   minor_neg;
    logic   x_major;
    color_t color;
  } cls_t;

  // one divider pipeline stage
  typedef struct packed {
    prod_t  rem;
    coord_t quo;
    coord_t len;
    coord_t minor_start;
    coord_t major;
    logic   minor_neg;
    logic   x_major;
    logic   valid;
    logic   last;
    logic   zero_len;
    color_t color;
  } div_stage_t;

endpackage
`default_nettype wire

[src/lpi_front.sv]
`default_nettype none
module lpi_front (
  input  wire lpi_pkg::in_req_t req,
  output lpi_pkg::cls_t         cls
);
  import lpi_pkg::*;

  logic   dx_neg;
  logic   dy_neg;
  coord_t adx;
  coord_t ady;
  logic   x_major;

  always_comb begin
    dx_neg  = req.x_end < req.x_start;
    dy_neg  = req.y_end < req.y_start;
    adx     = dx_neg ? req.x_start - req.x_end : req.x_end - req.x_start;
    ady     = dy_neg ? req.y_start - req.y_end : req.y_end - req.y_start;
    x_major = adx >= ady;

    cls.step  = req.step_index;
    cls.color = req.pixel_color;
    cls.x_major = x_major;
    if (x_major) begin
      cls.major_start = req.x_start;
      cls.minor_start = req.y_start;
      cls.len         = adx;
      cls.minor_mag   = ady;
      cls.major_neg   = dx_neg;
      cls.minor_neg   = dy_neg;
    end else begin
      cls.major_start = req.y_start;
      cls.minor_start = req.x_start;
      cls.len         = ady;
      cls.minor_mag   = adx;
      cls.major_neg   = dy_neg;
      cls.minor_neg   = dx_neg;
    end
  end

endmodule
`default_nettype wire

[src/lpi_queue.sv]
`default_nettype none
module lpi_queue #(
  parameter int DEPTH = lpi_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr,
  input  wire lpi_pkg::cls_t wr_data,
  output logic               full,
  input  wire logic          rd,
  output lpi_pkg::cls_t      rd_data,
  output logic               empty
);
  import lpi_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cls_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full    = count == CW'(DEPTH);
  assign empty   = count == '0;
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count beyond depth");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == CW'(DEPTH)) |-> wr_ptr == rd_ptr)
    else $error("queue pointers disagree with count");
  a_fill: assert property (@(posedge clk) disable iff (rst)
    (do_wr && !do_rd) |=> !empty)
    else $error("queue lost a written entry");
`endif

endmodule
`default_nettype wire

[src/lpi_back.sv]
`default_nettype none
module lpi_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire lpi_pkg::cls_t cls,
  input  wire logic          cls_avail,
  output logic               cls_take,
  output lpi_pkg::out_res_t  res,
  output logic               empty,
  input  wire logic          pop
);
  import lpi_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int DW = PROD_BITS;

  div_stage_t st [CB+1];
  logic       v  [CB+1];
  logic       out_v;
  logic       adv;
  div_stage_t s0_next;
  coord_t     minor;
  out_res_t   res_next;

  assign adv      = !out_v || pop;
  assign cls_take = adv && cls_avail;
  assign empty    = !out_v;

  // setup: major coordinate, range flags, minor product
  always_comb begin
    s0_next.rem         = DW'(cls.minor_mag) * DW'(cls.step);
    s0_next.quo         = '0;
    s0_next.len         = cls.len;
    s0_next.minor_start = cls.minor_start;
    s0_next.major       = cls.major_neg ? cls.major_start - cls.step
                                        : cls.major_start + cls.step;
    s0_next.minor_neg   = cls.minor_neg;
    s0_next.x_major     = cls.x_major;
    s0_next.valid       = cls.step <= cls.len;
    s0_next.last        = cls.step == cls.len;
    s0_next.zero_len    = cls.len == '0;
    s0_next.color       = cls.color;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0] <= s0_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (adv) begin
      v[0] <= cls_avail;
    end
  end

  // restoring division, one quotient bit per stage, msb first
  for (genvar j = 0; j < CB; j++) begin : g_div
    localparam int B = CB - 1 - j;
    prod_t      divs;
    logic       ge;
    div_stage_t nxt;

    always_comb begin
      divs    = DW'(st[j].len) << B;
      ge      = st[j].rem >= divs;
      nxt     = st[j];
      if (ge) begin
        nxt.rem    = st[j].rem - divs;
        nxt.quo[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st[j+1] <= nxt;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j+1] <= 1'b0;
      end else if (adv) begin
        v[j+1] <= v[j];
      end
    end
  end

  always_comb begin
    coord_t q;
    q     = st[CB].zero_len ? '0 : st[CB].quo;
    minor = st[CB].minor_neg ? st[CB].minor_start - q : st[CB].minor_start + q;
    res_next.out_color   = st[CB].color;
    res_next.in_range    = st[CB].valid;
    res_next.final_pixel = st[CB].valid && st[CB].last;
    if (!st[CB].valid) begin
      res_next.pixel_x = '0;
      res_next.pixel_y = '0;
    end else if (st[CB].x_major) begin
      res_next.pixel_x = st[CB].major;
      res_next.pixel_y = minor;
    end else begin
      res_next.pixel_x = minor;
      res_next.pixel_y = st[CB].major;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (adv) begin
      out_v <= v[CB];
    end
  end

`ifndef SYNTHESIS
  a_last_in_range: assert property (@(posedge clk) disable iff (rst)
    (out_v && res.final_pixel) |-> res.in_range)
    else $error("final pixel outside line");
  a_past_end_zero: assert property (@(posedge clk) disable iff (rst)
    (out_v && !res.in_range) |-> (res.pixel_x == '0 && res.pixel_y == '0))
    else $error("pixel past end not cleared");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (v[CB] && adv) |=> out_v)
    else $error("result dropped at output");
`endif

endmodule
`default_nettype wire

[src/line_pixel_interpolator_unit.sv]
`default_nettype none
// path: a request accepted into the queue passes through queue write, setup with multiply,
// one divider stage per bit, then the output register
// throughput: one request per cycle while the output is not stalled by pop, set by the pipelined restoring divider
// a QUEUE_DEPTH-entry queue (4 by default) between classification and the divider pipeline absorbs stalls
// reset: synchronous, clears queue pointers and all pipeline valid bits
module line_pixel_interpolator_unit #(
  parameter int QUEUE_DEPTH = lpi_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire lpi_pkg::in_req_t req,
  output logic                  empty,
  input  wire logic             pop,
  output lpi_pkg::out_res_t     res
);
  import lpi_pkg::*;

  cls_t cls_in;
  cls_t cls_out;
  logic q_empty;
  logic q_take;

  lpi_front u_front (
    .req (req),
    .cls (cls_in)
  );

  lpi_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (push),
    .wr_data (cls_in),
    .full    (full),
    .rd      (q_take),
    .rd_data (cls_out),
    .empty   (q_empty)
  );

  lpi_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cls       (cls_out),
    .cls_avail (!q_empty),
    .cls_take  (q_take),
    .res       (res),
    .empty     (empty),
    .pop       (pop)
  );

endmodule
`default_nettype wire
